@@ design/teq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// teq_pkg
// Shared constants and command codes for the timed event queue.
// ---------------------------------------------------------------------------
package teq_pkg;

  localparam int unsigned DefQueueDepth = 32;
  localparam int unsigned DefTimeBits   = 48;
  localparam int unsigned DefTagBits    = 16;
  localparam int unsigned OccBits       = 6;

  localparam logic [1:0] CMD_ADD_ABS  = 2'd0;
  localparam logic [1:0] CMD_ADD_REL  = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_KILL_ALL = 2'd3;

endpackage : teq_pkg
`default_nettype wire

@@ design/teq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// teq_cmd_if / teq_res_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface teq_cmd_if #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [TIME_BITS-1:0] time_value;
  logic [TAG_BITS-1:0]  event_tag;
  logic [31:0]          tick_amount;

  modport source (output valid, command, time_value, event_tag, tick_amount,
                  input ready);
  modport sink   (input valid, command, time_value, event_tag, tick_amount,
                  output ready);
endinterface : teq_cmd_if

interface teq_res_if #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [TAG_BITS-1:0]  fired_tag;
  logic                 fired_valid;
  logic                 last_of_run;
  logic                 status;
  logic [TIME_BITS-1:0] time_now;
  logic [5:0]           occupancy;

  modport source (output valid, fired_tag, fired_valid, last_of_run, status,
                  time_now, occupancy, input ready);
  modport sink   (input valid, fired_tag, fired_valid, last_of_run, status,
                  time_now, occupancy, output ready);
endinterface : teq_res_if
`default_nettype wire

@@ design/timed_event_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// timed_event_queue
// Deadline-ordered event table with a saturating time counter.
// ---------------------------------------------------------------------------
// Events live in a circular buffer held in one synchronous memory, sorted by
// deadline from the head. An add walks from the tail towards the head,
// shifting later entries up by one (read then write back), and offers its
// result beat once the new event is placed. A full add, a kill-all and a
// tick with kill pending offer their beat in the cycle after the accept. A
// tick reads the head and compares it with the clock; with nothing due it
// offers one beat. A tick that fires offers each fired beat after the next
// head is read to decide the last flag, and a further beat only after the
// previous one is taken. One item is worked on at a time: a new command is
// taken only in idle with no beat waiting, so the cycle after the last beat
// is taken at the earliest.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned TIME_BITS   = DefTimeBits,
  parameter int unsigned TAG_BITS    = DefTagBits
) (
  input  wire logic clk,
  input  wire logic rst,
  teq_cmd_if.sink   cmd,
  teq_res_if.source res
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INSRD = 3'd1;  // read entry below insert point, or place at head
  localparam logic [2:0] S_INSCK = 3'd2;  // compare and shift or place
  localparam logic [2:0] S_TKRD  = 3'd3;  // read head
  localparam logic [2:0] S_TKCK  = 3'd4;  // compare head with clock
  localparam logic [2:0] S_TKNX  = 3'd5;  // look at next head, send beat
  localparam logic [2:0] S_OUT   = 3'd6;  // wait for fired beat taken

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic   wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [2:0]           state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [CW-1:0]        count, count_next;
  logic [TIME_BITS-1:0] clock_count, clock_next;
  logic                 kill_pending, kill_next;
  entry_t               new_ent, new_ent_next;
  logic [CW-1:0]        pos, pos_next;     // offset from head of the hole

  logic                 r_valid, r_valid_next;
  logic [TAG_BITS-1:0]  r_tag, r_tag_next;
  logic                 r_fv, r_fv_next, r_last, r_last_next, r_st, r_st_next;
  logic [CW-1:0]        r_occ, r_occ_next;

  logic [TIME_BITS:0]   rel_sum;
  logic [TIME_BITS:0]   tick_sum;
  logic                 head_due;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW+CW:0] s;
    s = (AW+CW+1)'(base) + (AW+CW+1)'(off);
    if (s >= (AW+CW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+CW+1)'(QUEUE_DEPTH);
    end
    return AW'(s);
  endfunction

  assign rel_sum  = {1'b0, clock_count} + {1'b0, cmd.time_value};
  assign tick_sum = {1'b0, clock_count} + (TIME_BITS+1)'(cmd.tick_amount);

  // entry at the head (as last read) is pending and has expired
  assign head_due = (count != '0) && (rd_data.deadline <= clock_count);

  assign cmd.ready = (state == S_IDLE) && !r_valid;

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    clock_next     = clock_count;
    kill_next      = kill_pending;
    new_ent_next   = new_ent;
    pos_next       = pos;
    r_valid_next   = r_valid;
    r_tag_next     = r_tag;
    r_fv_next      = r_fv;
    r_last_next    = r_last;
    r_st_next      = r_st;
    r_occ_next     = r_occ;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = new_ent;
    rd_addr        = '0;

    if (r_valid && res.ready) begin
      r_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          r_tag_next  = '0;
          r_fv_next   = 1'b0;
          r_last_next = 1'b1;
          r_st_next   = 1'b0;
          r_occ_next  = count;
          case (cmd.command)
            CMD_ADD_ABS, CMD_ADD_REL: begin
              new_ent_next.tag = cmd.event_tag;
              if (cmd.command == CMD_ADD_ABS) begin
                new_ent_next.deadline = cmd.time_value;
              end else begin
                new_ent_next.deadline = rel_sum[TIME_BITS] ? TMAX
                                        : rel_sum[TIME_BITS-1:0];
              end
              if (count == DEPTH_C) begin
                r_st_next    = 1'b1;
                r_valid_next = 1'b1;
              end else begin
                pos_next   = count;
                state_next = S_INSRD;
              end
            end
            CMD_KILL_ALL: begin
              kill_next    = 1'b1;
              r_valid_next = 1'b1;
            end
            default: begin
              clock_next = tick_sum[TIME_BITS] ? TMAX : tick_sum[TIME_BITS-1:0];
              if (kill_pending) begin
                kill_next    = 1'b0;
                count_next   = '0;
                r_occ_next   = '0;
                r_valid_next = 1'b1;
              end else begin
                state_next = S_TKRD;
              end
            end
          endcase
        end
      end
      S_INSRD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          wr_addr    = head;
          count_next = count + 1'b1;
          r_occ_next = count + 1'b1;
          r_valid_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_addr    = wrap(head, pos - 1'b1);
          state_next = S_INSCK;
        end
      end
      S_INSCK: begin
        wr_en = 1'b1;
        wr_addr = wrap(head, pos);
        if (rd_data.deadline > new_ent.deadline) begin
          wr_data    = rd_data;
          pos_next   = pos - 1'b1;
          state_next = S_INSRD;
        end else begin
          count_next   = count + 1'b1;
          r_occ_next   = count + 1'b1;
          r_valid_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TKRD: begin
        rd_addr    = head;
        state_next = S_TKCK;
      end
      S_TKCK: begin
        // only reached with no beat waiting; from S_OUT the head is known due
        if (head_due) begin
          r_tag_next = rd_data.tag;
          r_fv_next  = 1'b1;
          r_occ_next = count - 1'b1;
          head_next  = wrap(head, CW'(1));
          count_next = count - 1'b1;
          rd_addr    = wrap(head, CW'(1));
          state_next = S_TKNX;
        end else begin
          r_fv_next    = 1'b0;
          r_last_next  = 1'b1;
          r_occ_next   = count;
          r_valid_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TKNX: begin
        // rd_data now holds the new head; keep reading it while the beat waits
        rd_addr      = head;
        r_last_next  = !head_due;
        r_valid_next = 1'b1;
        state_next   = head_due ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        rd_addr = head;
        if (!r_valid_next) begin
          state_next = S_TKCK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      clock_count  <= '0;
      kill_pending <= 1'b0;
      r_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      count        <= count_next;
      clock_count  <= clock_next;
      kill_pending <= kill_next;
      r_valid      <= r_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    new_ent <= new_ent_next;
    pos     <= pos_next;
    r_tag   <= r_tag_next;
    r_fv    <= r_fv_next;
    r_last  <= r_last_next;
    r_st    <= r_st_next;
    r_occ   <= r_occ_next;
  end

  assign res.valid       = r_valid;
  assign res.fired_tag   = r_tag;
  assign res.fired_valid = r_fv;
  assign res.last_of_run = r_last;
  assign res.status      = r_st;
  assign res.time_now    = clock_count;
  assign res.occupancy   = 6'(r_occ);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("entry count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> (state == S_IDLE && !r_valid))
    else $error("command taken while busy");
  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status) |-> (count == DEPTH_C))
    else $error("full status with room left");
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> clock_count >= $past(clock_count))
    else $error("time counter went backwards");
`endif

endmodule : timed_event_queue
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the timed event queue: command beats are predicted into expected
// result beats, which the monitor compares field by field as they arrive.
// ---------------------------------------------------------------------------
module testbench
  import teq_pkg::*;
();

  localparam int Depth = 32;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] time_value;
    logic [15:0] event_tag;
    logic [31:0] tick_amount;
  } cmd_beat_t;

  typedef struct packed {
    logic [15:0] fired_tag;
    logic        fired_valid;
    logic        last_of_run;
    logic        status;
    logic [47:0] time_now;
    logic [5:0]  occupancy;
  } res_beat_t;

  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  teq_cmd_if #(.TIME_BITS(48), .TAG_BITS(16)) cmd ();
  teq_res_if #(.TIME_BITS(48), .TAG_BITS(16)) res ();

  timed_event_queue DUT (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [47:0] sched_deadline[Depth];
  logic [15:0] sched_tag[Depth];
  int          sched_count;
  logic [47:0] clock_now;
  logic        kill_armed;

  cmd_beat_t pending_cmds[$];
  res_beat_t expected_results[$];
  int        mismatches;
  bit        hold_rx = 1'b0;

  function automatic logic [47:0] sat_time(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TimeMax : s[47:0];
  endfunction

  function automatic res_beat_t make_res(logic [15:0] tag, logic fv, logic last,
                                         logic full, int occ);
    res_beat_t r;
    r.fired_tag = tag;
    r.fired_valid = fv;
    r.last_of_run = last;
    r.status = full;
    r.time_now = clock_now;
    r.occupancy = 6'(occ);
    return r;
  endfunction

  task automatic predict_schedule(cmd_beat_t c);
    logic [47:0] dl;
    int pos;
    int fired;
    if (c.command == CMD_ADD_ABS || c.command == CMD_ADD_REL) begin
      dl = (c.command == CMD_ADD_ABS) ? c.time_value : sat_time(clock_now, c.time_value);
      if (sched_count >= Depth) begin
        expected_results.push_back(make_res(16'd0, 1'b0, 1'b1, 1'b1, sched_count));
      end else begin
        pos = sched_count;
        while (pos > 0 && sched_deadline[pos-1] > dl) begin
          sched_deadline[pos] = sched_deadline[pos-1];
          sched_tag[pos] = sched_tag[pos-1];
          pos--;
        end
        sched_deadline[pos] = dl;
        sched_tag[pos] = c.event_tag;
        sched_count++;
        expected_results.push_back(make_res(16'd0, 1'b0, 1'b1, 1'b0, sched_count));
      end
    end else if (c.command == CMD_KILL_ALL) begin
      kill_armed = 1'b1;
      expected_results.push_back(make_res(16'd0, 1'b0, 1'b1, 1'b0, sched_count));
    end else begin
      clock_now = sat_time(clock_now, {16'd0, c.tick_amount});
      if (kill_armed) begin
        sched_count = 0;
        kill_armed = 1'b0;
        expected_results.push_back(make_res(16'd0, 1'b0, 1'b1, 1'b0, 0));
      end else begin
        fired = 0;
        while (fired < sched_count && sched_deadline[fired] <= clock_now) fired++;
        if (fired == 0) begin
          expected_results.push_back(make_res(16'd0, 1'b0, 1'b1, 1'b0, sched_count));
        end else begin
          for (int i = 0; i < fired; i++)
            expected_results.push_back(make_res(sched_tag[i], 1'b1, i + 1 == fired,
                                                1'b0, sched_count - i - 1));
          for (int i = 0; i + fired < sched_count; i++) begin
            sched_deadline[i] = sched_deadline[i+fired];
            sched_tag[i] = sched_tag[i+fired];
          end
          sched_count -= fired;
        end
      end
    end
  endtask

  function automatic cmd_beat_t mk(logic [1:0] op, logic [47:0] tv, logic [15:0] tg,
                                   logic [31:0] amt);
    cmd_beat_t c;
    c.command = op;
    c.time_value = tv;
    c.event_tag = tg;
    c.tick_amount = amt;
    return c;
  endfunction

  function automatic cmd_beat_t rand_cmd(int mode);
    logic [1:0] op;
    logic [47:0] tv;
    case ($urandom_range(0, 9))
      0, 1, 2: op = CMD_ADD_ABS;
      3, 4, 5: op = CMD_ADD_REL;
      9:       op = (mode == 0) ? CMD_KILL_ALL : CMD_TICK;
      default: op = CMD_TICK;
    endcase
    case ($urandom_range(0, 5))
      0:       tv = 48'({$urandom, $urandom});
      1:       tv = TimeMax - 48'($urandom_range(0, 3));
      default: tv = (op == CMD_ADD_ABS) ? clock_now + 48'($urandom_range(0, 3000))
                                        : 48'($urandom_range(0, 3000));
    endcase
    return mk(op, tv, 16'($urandom),
              ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 1500));
  endfunction

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      send_gap <= 0;
    end else if (cmd.valid && !cmd.ready) begin
      // hold the beat
    end else if (send_gap > 0) begin
      cmd.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_cmds.size() > 0) begin
      cmd_beat_t c;
      c = pending_cmds.pop_front();
      predict_schedule(c);
      cmd.valid <= 1'b1;
      {cmd.command, cmd.time_value, cmd.event_tag, cmd.tick_amount} <= c;
      send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    end else begin
      cmd.valid <= 1'b0;
    end
  end

  // monitor
  int recv_gap;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res.valid && res.ready) begin
        res_beat_t got;
        res_beat_t want;
        got = {res.fired_tag, res.fired_valid, res.last_of_run, res.status,
               res.time_now, res.occupancy};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected tag %h fv %b last %b st %b t %h occ %0d,",
                        " got tag %h fv %b last %b st %b t %h occ %0d"},
                       want.fired_tag, want.fired_valid, want.last_of_run, want.status,
                       want.time_now, want.occupancy, got.fired_tag, got.fired_valid,
                       got.last_of_run, got.status, got.time_now, got.occupancy);
          end
        end
      end
      if (hold_rx) begin
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        res.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        res.ready <= 1'b1;
        recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || cmd.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.command = CMD_TICK;
    cmd.time_value = '0;
    cmd.event_tag = '0;
    cmd.tick_amount = '0;
    res.ready = 1'b0;
    sched_count = 0;
    clock_now = '0;
    kill_armed = 1'b0;
    mismatches = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ordering, ties, past deadline, kill, saturation
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_ABS, 48'd50, 16'hFFFF, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_ABS, 48'd20, 16'h0001, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_ABS, 48'd20, 16'h0002, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_REL, 48'd0, 16'h0000, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'd30));
    pending_cmds.push_back(mk(CMD_ADD_ABS, 48'd0, 16'h1234, 32'd0));
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'd100));
    pending_cmds.push_back(mk(CMD_KILL_ALL, 48'd0, 16'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_KILL_ALL, 48'd0, 16'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_REL, 48'd5, 16'hAAAA, 32'd0));
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'd1));
    pending_cmds.push_back(mk(CMD_ADD_REL, TimeMax, 16'h5555, 32'd0));
    pending_cmds.push_back(mk(CMD_ADD_ABS, TimeMax, 16'h00FF, 32'd0));
    wait_drained();

    // fill the table past full; the result channel is held back at the start
    for (int i = 0; i < 34; i++)
      pending_cmds.push_back(mk(CMD_ADD_ABS, 48'($urandom_range(0, 40)),
                                16'($urandom), 32'd0));
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'hFFFF_FFFF));
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    wait_drained();
    // large ticks; entries at the time maximum stay pending until the kill
    for (int i = 0; i < 3; i++)
      pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(CMD_KILL_ALL, 48'd0, 16'd0, 32'd0));
    pending_cmds.push_back(mk(CMD_TICK, 48'd0, 16'd0, 32'd0));
    wait_drained();

    // random mix, with pauses until every expected beat is back
    for (int n = 0; n < 106; n++) begin
      pending_cmds.push_back(rand_cmd(n % 35 == 34 ? 0 : 1));
      if (n % 8 == 7) wait_drained();
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("timed_event_queue test passed");
    end else begin
      $display("timed_event_queue test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timed_event_queue test failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/teq_pkg.sv
design/teq_if.sv
design/timed_event_queue.sv
tb/testbench.sv
